@@ rtl/bde_pkg.sv @@
package bde_pkg;

    localparam int DEPTH_DEF   = 32;
    localparam int MAX_RESULTS = 32;
    localparam int VAL_W       = 32;
    localparam int OPC_W       = 4;

    localparam logic [OPC_W-1:0] OP_PUSH_FRONT = 4'd0;
    localparam logic [OPC_W-1:0] OP_PUSH_BACK  = 4'd1;
    localparam logic [OPC_W-1:0] OP_POP_FRONT  = 4'd2;
    localparam logic [OPC_W-1:0] OP_POP_BACK   = 4'd3;
    localparam logic [OPC_W-1:0] OP_CLEAR      = 4'd4;
    localparam logic [OPC_W-1:0] OP_DELETE     = 4'd5;
    localparam logic [OPC_W-1:0] OP_FIRST_N    = 4'd6;
    localparam logic [OPC_W-1:0] OP_LAST_N     = 4'd7;
    localparam logic [OPC_W-1:0] OP_ALL        = 4'd8;

    typedef struct packed {
        logic load;
        logic del_step;
        logic del_finish;
        logic print_load;
        logic empty_load;
    } cmd_t;

    typedef struct packed {
        logic walk_done;
        logic len_zero;
        logic out_last;
    } sts_t;

endpackage

@@ rtl/bde_ram.sv @@
module bde_ram #(
    parameter int WIDTH = bde_pkg::VAL_W,
    parameter int DEPTH = bde_pkg::DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/bde_ctrl.sv @@
module bde_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bde_pkg::OPC_W-1:0]      opcode,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output bde_pkg::cmd_t                  cmd,
    input  bde_pkg::sts_t                  sts
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DPRE = 3'd1;
    localparam logic [2:0] S_DEL  = 3'd2;
    localparam logic [2:0] S_PPRE = 3'd3;
    localparam logic [2:0] S_PLD  = 3'd4;
    localparam logic [2:0] S_PWT  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;
    logic       is_print;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_PWT);
    assign accept   = s_tvalid && s_tready;
    assign is_print = (opcode == bde_pkg::OP_FIRST_N) || (opcode == bde_pkg::OP_LAST_N)
                      || (opcode == bde_pkg::OP_ALL);

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.load       = accept;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == bde_pkg::OP_DELETE)
                    begin
                        state_next = S_DPRE;
                    end
                    else if (is_print)
                    begin
                        state_next = S_PPRE;
                    end
                end
            end
            S_DPRE:
            begin
                state_next = S_DEL;
            end
            S_DEL:
            begin
                if (sts.walk_done)
                begin
                    cmd.del_finish = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.del_step = 1'b1;
                end
            end
            S_PPRE:
            begin
                if (sts.len_zero)
                begin
                    cmd.empty_load = 1'b1;
                    state_next     = S_PWT;
                end
                else
                begin
                    state_next = S_PLD;
                end
            end
            S_PLD:
            begin
                cmd.print_load = 1'b1;
                state_next     = S_PWT;
            end
            S_PWT:
            begin
                if (m_tready)
                begin
                    if (sts.out_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.print_load = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/bde_dp.sv @@
module bde_dp #(
    parameter int DEPTH = bde_pkg::DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [bde_pkg::OPC_W-1:0]         opcode,
    input  logic signed [bde_pkg::VAL_W-1:0]  operand,
    input  bde_pkg::cmd_t                     cmd,
    output bde_pkg::sts_t                     sts,
    output logic signed [bde_pkg::VAL_W-1:0]  out_value,
    output logic                              has_value,
    output logic                              last_of_run,
    output logic                              overflowed
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int VW = bde_pkg::VAL_W;

    logic [AW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic          ovf_reg;
    logic [VW-1:0] operand_reg;
    logic [CW-1:0] len_reg;
    logic [CW-1:0] base_reg;
    logic [CW-1:0] k_reg;
    logic [CW-1:0] kept_reg;
    logic [VW-1:0] out_value_reg;
    logic          has_value_reg;
    logic          last_reg;

    logic          full;
    logic          adv;
    logic [CW-1:0] rd_pos;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic [VW-1:0] wdata;
    logic          we;
    logic [VW-1:0] rdata;
    logic          sel_all;
    logic [CW-1:0] n_low;
    logic [CW-1:0] len_sel;
    logic [CW-1:0] len_cap;
    logic [CW-1:0] base_sel;
    logic          keep;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h, input logic [CW-1:0] p);
        logic [SW-1:0] s;
        s = {{(SW - AW){1'b0}}, h} + {1'b0, p};
        if (s >= SW'(DEPTH))
        begin
            s = s - SW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign full   = (count_reg == CW'(DEPTH));
    assign adv    = cmd.print_load || cmd.del_step;
    assign rd_pos = base_reg + k_reg + (adv ? CW'(1) : CW'(0));
    assign raddr  = slot_of(head_reg, rd_pos);
    assign keep   = (rdata != operand_reg);

    always_comb
    begin
        we    = 1'b0;
        waddr = slot_of(head_reg, kept_reg);
        wdata = rdata;
        if (cmd.load)
        begin
            wdata = operand;
            if (opcode == bde_pkg::OP_PUSH_FRONT)
            begin
                we    = !full;
                waddr = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
            end
            else if (opcode == bde_pkg::OP_PUSH_BACK)
            begin
                we    = !full;
                waddr = slot_of(head_reg, count_reg);
            end
        end
        else if (cmd.del_step)
        begin
            we = keep;
        end
    end

    bde_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        sel_all = (opcode == bde_pkg::OP_ALL) || operand[VW-1]
                  || (operand >= VW'(count_reg));
        n_low   = operand[CW-1:0];
        if (opcode == bde_pkg::OP_DELETE)
        begin
            len_sel  = count_reg;
            base_sel = '0;
        end
        else if (sel_all)
        begin
            len_sel  = count_reg;
            base_sel = '0;
        end
        else
        begin
            len_sel  = n_low;
            base_sel = (opcode == bde_pkg::OP_LAST_N) ? count_reg - n_low : '0;
        end
        if ((opcode != bde_pkg::OP_DELETE) && (32'(len_sel) > 32'(bde_pkg::MAX_RESULTS)))
        begin
            len_cap = CW'(bde_pkg::MAX_RESULTS);
        end
        else
        begin
            len_cap = len_sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.load)
        begin
            case (opcode)
                bde_pkg::OP_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        ovf_reg <= 1'b1;
                    end
                    else
                    begin
                        head_reg  <= (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
                        count_reg <= count_reg + CW'(1);
                    end
                end
                bde_pkg::OP_PUSH_BACK:
                begin
                    if (full)
                    begin
                        ovf_reg <= 1'b1;
                    end
                    else
                    begin
                        count_reg <= count_reg + CW'(1);
                    end
                end
                bde_pkg::OP_POP_FRONT:
                begin
                    if (count_reg != '0)
                    begin
                        count_reg <= count_reg - CW'(1);
                        if (count_reg == CW'(1))
                        begin
                            head_reg <= '0;
                        end
                        else
                        begin
                            head_reg <= (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
                        end
                    end
                end
                bde_pkg::OP_POP_BACK:
                begin
                    if (count_reg != '0)
                    begin
                        count_reg <= count_reg - CW'(1);
                        if (count_reg == CW'(1))
                        begin
                            head_reg <= '0;
                        end
                    end
                end
                bde_pkg::OP_CLEAR:
                begin
                    count_reg <= '0;
                    head_reg  <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.del_finish)
        begin
            count_reg <= kept_reg;
            if (kept_reg == '0)
            begin
                head_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            operand_reg <= operand;
            len_reg     <= len_cap;
            base_reg    <= base_sel;
            k_reg       <= '0;
            kept_reg    <= '0;
        end
        else if (adv)
        begin
            k_reg <= k_reg + CW'(1);
        end
        if (cmd.del_step && keep)
        begin
            kept_reg <= kept_reg + CW'(1);
        end
        if (cmd.print_load)
        begin
            out_value_reg <= rdata;
            has_value_reg <= 1'b1;
            last_reg      <= ((k_reg + CW'(1)) == len_reg);
        end
        else if (cmd.empty_load)
        begin
            out_value_reg <= '0;
            has_value_reg <= 1'b0;
            last_reg      <= 1'b1;
        end
    end

    assign sts.walk_done = (k_reg == len_reg);
    assign sts.len_zero  = (len_reg == '0);
    assign sts.out_last  = last_reg;

    assign out_value   = out_value_reg;
    assign has_value   = has_value_reg;
    assign last_of_run = last_reg;
    assign overflowed  = ovf_reg;

endmodule

@@ rtl/bounded_deque_engine.sv @@
// Bounded deque of up to DEPTH signed 32-bit entries, one command per input item.
// Input channel s_*: s_tuser carries the opcode, s_tdata the operand.
// Output channel m_*: one item per printed entry; m_tlast marks the final item
// of a print, m_tuser[0] flags a valid value (low on the single item of an
// empty print), m_tuser[1] is the sticky overflow flag.
// One command at a time (s_tready is low while a command is in progress):
//   push, pop, clear, unused opcodes: done on accept; s_tready stays high.
//   delete by value: walks the stored entries, one stored entry per cycle
//     through the single read and single write port of the entry RAM.
//   print: the first entry is read from RAM and loaded into the output
//     register (an empty print loads its single empty item directly), then
//     one item per cycle while m_tready is high, the RAM read issued one ahead.
// When the receiver stalls, the output item and its flags hold and the walk
// pauses. Reset clears head, count and overflow flag; entry contents are left
// as they are and are never read before being written.
module bounded_deque_engine #(
    parameter int DEPTH = bde_pkg::DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic signed [bde_pkg::VAL_W-1:0] s_tdata,   // operand
    input  logic [bde_pkg::OPC_W-1:0]        s_tuser,   // opcode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic signed [bde_pkg::VAL_W-1:0] m_tdata,   // out_value
    output logic [1:0]                       m_tuser,   // overflowed, has_value
    output logic                             m_tlast
);

    bde_pkg::cmd_t cmd;
    bde_pkg::sts_t sts;
    logic          has_value;
    logic          overflowed;

    bde_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    bde_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .opcode      (s_tuser),
        .operand     (s_tdata),
        .cmd         (cmd),
        .sts         (sts),
        .out_value   (m_tdata),
        .has_value   (has_value),
        .last_of_run (m_tlast),
        .overflowed  (overflowed)
    );

    assign m_tuser = {overflowed, has_value};

endmodule
